@@ sv/websocket_frame_deframer_top_assert.svh @@
// ----------------------------------------------------------------------------
// WebSocket deframer assertion macros
// Concurrent checks that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DEFRAMER_TOP_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define WSFD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define WSFD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define WSFD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg)
`define WSFD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

@@ sv/wsfd_pkg.sv @@
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Shared widths, protocol constants, register indexes and the result struct.
// ----------------------------------------------------------------------------
`default_nettype none
package wsfd_pkg;

    localparam int BYTE_W    = 8;
    localparam int OPC_W     = 4;
    localparam int LEN_W     = 64;
    localparam int CFG_LEN_W = 16;
    localparam int CFG_IDX_W = 8;
    localparam int TUSER_W   = 8;
    localparam int KEY_W     = 32;
    localparam int CNT_W     = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LEN = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN = 8'd1;

    localparam logic [CFG_LEN_W-1:0] MIN_LEN_RST = 16'd4;
    localparam logic [CFG_LEN_W-1:0] MAX_LEN_RST = 16'd65534;

    // second header byte length codes
    localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
    localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

    // header byte counts
    localparam logic [CNT_W-1:0] EXT16_BYTES = 4'd2;
    localparam logic [CNT_W-1:0] EXT64_BYTES = 4'd8;
    localparam logic [CNT_W-1:0] KEY_BYTES   = 4'd4;

    // data opcodes
    localparam logic [OPC_W-1:0] OPC_TEXT   = 4'd1;
    localparam logic [OPC_W-1:0] OPC_BINARY = 4'd2;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
        logic [OPC_W-1:0]  opcode;
        logic              fin;
        logic              last;
    } t_result;

endpackage
`default_nettype wire

@@ sv/wsfd_parser.sv @@
// ----------------------------------------------------------------------------
// WebSocket deframer header parser
// Holds the frame parse state and turns one byte per step into at most one
// unmasked payload result.
// ----------------------------------------------------------------------------
`default_nettype none
module wsfd_parser (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_step,
    input  wire logic [wsfd_pkg::BYTE_W-1:0]    i_byte,
    input  wire logic [wsfd_pkg::CFG_LEN_W-1:0] i_min_len,
    input  wire logic [wsfd_pkg::CFG_LEN_W-1:0] i_max_len,
    output wsfd_pkg::t_result                   o_res
);
    import wsfd_pkg::*;

`include "websocket_frame_deframer_top_assert.svh"

    typedef enum logic [2:0] {
        PH_HDR1    = 3'd0,
        PH_HDR2    = 3'd1,
        PH_EXT16   = 3'd2,
        PH_EXT64   = 3'd3,
        PH_KEY     = 3'd4,
        PH_PAYLOAD = 3'd5
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_fin, n_fin;
    logic [OPC_W-1:0]   r_opc, n_opc;
    logic               r_masked, n_masked;
    logic [LEN_W-1:0]   r_len, n_len;     // length while parsing, bytes left in payload
    logic [KEY_W-1:0]   r_key, n_key;
    logic [1:0]         r_kidx, n_kidx;
    logic               r_deliver, n_deliver;

    logic               w_len_done;
    logic               w_begin;
    logic [BYTE_W-1:0]  w_key_byte;
    logic [CNT_W-1:0]   w_cnt_inc;

    assign w_cnt_inc = r_cnt + 4'd1;

    always_comb begin
        unique case (r_kidx)
            2'd0:    w_key_byte = r_key[31:24];
            2'd1:    w_key_byte = r_key[23:16];
            2'd2:    w_key_byte = r_key[15:8];
            default: w_key_byte = r_key[7:0];
        endcase
    end

    always_comb begin
        n_phase    = r_phase;
        n_cnt      = r_cnt;
        n_fin      = r_fin;
        n_opc      = r_opc;
        n_masked   = r_masked;
        n_len      = r_len;
        n_key      = r_key;
        n_kidx     = r_kidx;
        n_deliver  = r_deliver;
        w_len_done = 1'b0;
        w_begin    = 1'b0;
        o_res      = '0;

        unique case (r_phase) inside
            PH_HDR2: begin
                n_masked = i_byte[7];
                n_key    = '0;
                n_cnt    = '0;
                n_len    = '0;
                if (i_byte[6:0] == LEN_CODE_EXT16) begin
                    n_phase = PH_EXT16;
                end else if (i_byte[6:0] == LEN_CODE_EXT64) begin
                    n_phase = PH_EXT64;
                end else begin
                    n_len      = {57'd0, i_byte[6:0]};
                    w_len_done = 1'b1;
                end
            end
            PH_EXT16, PH_EXT64: begin
                n_len = {r_len[LEN_W-BYTE_W-1:0], i_byte};
                n_cnt = w_cnt_inc;
                if (w_cnt_inc >= ((r_phase == PH_EXT16) ? EXT16_BYTES : EXT64_BYTES)) begin
                    w_len_done = 1'b1;
                end
            end
            PH_KEY: begin
                n_key = {r_key[KEY_W-BYTE_W-1:0], i_byte};
                n_cnt = w_cnt_inc;
                if (w_cnt_inc >= KEY_BYTES) begin
                    n_cnt   = '0;
                    w_begin = 1'b1;
                end
            end
            PH_PAYLOAD: begin
                n_len        = r_len - 64'd1;
                n_kidx       = r_kidx + 2'd1;
                o_res.valid  = r_deliver;
                o_res.data   = r_masked ? (i_byte ^ w_key_byte) : i_byte;
                o_res.opcode = r_opc;
                o_res.fin    = r_fin;
                o_res.last   = (r_len == 64'd1);
                if (r_len == 64'd1) begin
                    n_phase = PH_HDR1;
                end
            end
            default: begin
                // first header byte, also for unused phase codes
                n_fin   = i_byte[7];
                n_opc   = i_byte[3:0];
                n_phase = PH_HDR2;
            end
        endcase

        if (w_len_done) begin
            n_cnt = '0;
            if (n_masked) begin
                n_phase = PH_KEY;
            end else begin
                w_begin = 1'b1;
            end
        end

        if (w_begin) begin
            n_deliver = ((r_opc == OPC_TEXT) || (r_opc == OPC_BINARY))
                        && (n_len[LEN_W-1:CFG_LEN_W] == '0)
                        && (n_len[CFG_LEN_W-1:0] >= i_min_len)
                        && (n_len[CFG_LEN_W-1:0] <= i_max_len);
            n_kidx    = '0;
            n_phase   = (n_len == '0) ? PH_HDR1 : PH_PAYLOAD;
        end

        if (!i_step) begin
            o_res.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HDR1;
            r_cnt     <= '0;
            r_fin     <= 1'b0;
            r_opc     <= '0;
            r_masked  <= 1'b0;
            r_len     <= '0;
            r_key     <= '0;
            r_kidx    <= '0;
            r_deliver <= 1'b0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_cnt     <= n_cnt;
            r_fin     <= n_fin;
            r_opc     <= n_opc;
            r_masked  <= n_masked;
            r_len     <= n_len;
            r_key     <= n_key;
            r_kidx    <= n_kidx;
            r_deliver <= n_deliver;
        end
    end

    // a result only comes from a payload byte of a frame marked for delivery
    `WSFD_ASSERT_NOW(a_res_src, i_clk, i_rst_n, o_res.valid,
        (r_phase == PH_PAYLOAD) && r_deliver && i_step, "result outside delivered payload")
    // payload phase always has bytes left
    `WSFD_ASSERT_NOW(a_pay_left, i_clk, i_rst_n, r_phase == PH_PAYLOAD, r_len != '0,
        "payload phase with no bytes left")
    // key bytes never overrun
    `WSFD_ASSERT_NOW(a_key_cnt, i_clk, i_rst_n, r_phase == PH_KEY, r_cnt < KEY_BYTES,
        "key byte count overrun")

endmodule
`default_nettype wire

@@ sv/websocket_frame_deframer_top.sv @@
// ----------------------------------------------------------------------------
// WebSocket frame deframer, top level
// Parses the received byte stream into frames and delivers unmasked payload.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis_*  : received stream bytes, one byte per item, after the handshake.
//   m_axis_*  : unmasked payload bytes of text/binary frames whose length
//               lies in [min_deliver_len, max_deliver_len]; tlast marks the
//               final payload byte of the frame. Header bytes, control and
//               continuation frames and out-of-window frames give no item.
//   i_cfg_*   : register writes, index 0 = min_deliver_len, 1 =
//               max_deliver_len; other indexes are ignored. Always ready.
//               Write only while the block is idle.
// Path: an accepted byte waits in the input register until the result stage
//   is free, then is parsed and its result, if any, is registered for m_axis.
// Throughput: one byte per cycle while m_axis_tready is high, set by the
//   single parse stage between the input register and the result register.
// Stall: while m_axis_tready is low the result is held; one more byte is
//   taken into the input register, then s_axis_tready drops.
// Reset: synchronous, active low; the parser waits for a first header byte,
//   min_deliver_len = 4, max_deliver_len = 65534, both stages empty.
// ----------------------------------------------------------------------------
`default_nettype none
module websocket_frame_deframer_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // input stream
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [wsfd_pkg::BYTE_W-1:0]    s_axis_tdata,   // [7:0] rx_byte
    // output stream
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [wsfd_pkg::BYTE_W-1:0]         m_axis_tdata,   // [7:0] payload_byte
    output logic [wsfd_pkg::TUSER_W-1:0]        m_axis_tuser,   // [3:0] frame_opcode,
                                                                // [4] frame_fin, [7:5] zero
    output logic                                m_axis_tlast,   // last_of_frame
    // configuration writes
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [wsfd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [wsfd_pkg::CFG_LEN_W-1:0] i_cfg_data
);
    import wsfd_pkg::*;

`include "websocket_frame_deframer_top_assert.svh"

    // config registers
    logic [CFG_LEN_W-1:0] r_min_len;
    logic [CFG_LEN_W-1:0] r_max_len;

    // input stage
    logic                 r_in_valid;
    logic [BYTE_W-1:0]    r_in_byte;

    // result stage
    logic                 r_out_valid;
    logic [BYTE_W-1:0]    r_out_data;
    logic [OPC_W-1:0]     r_out_opc;
    logic                 r_out_fin;
    logic                 r_out_last;

    logic                 w_adv;   // input stage byte goes through the parser
    t_result              w_res;

    assign o_cfg_ready   = 1'b1;
    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len <= MIN_LEN_RST;
            r_max_len <= MAX_LEN_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_MIN_LEN: r_min_len <= i_cfg_data;
                REG_MAX_LEN: r_max_len <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    wsfd_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_adv),
        .i_byte    (r_in_byte),
        .i_min_len (r_min_len),
        .i_max_len (r_max_len),
        .o_res     (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_res.valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_res.valid) begin
            r_out_data <= w_res.data;
            r_out_opc  <= w_res.opcode;
            r_out_fin  <= w_res.fin;
            r_out_last <= w_res.last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = {3'b000, r_out_fin, r_out_opc};
    assign m_axis_tlast  = r_out_last;

    // input can only be refused when both stages hold an item
    `WSFD_ASSERT_NOW(a_ready_full, i_clk, i_rst_n, !s_axis_tready, r_in_valid && r_out_valid, "input refused with a free stage")
    // a byte in the input stage is never dropped
    `WSFD_ASSERT_NEXT(a_in_kept, i_clk, i_rst_n, r_in_valid && !w_adv, r_in_valid, "input stage byte lost")
    // a result that is not taken stays
    `WSFD_ASSERT_NEXT(a_out_kept, i_clk, i_rst_n, r_out_valid && !m_axis_tready, r_out_valid, "pending result lost")

endmodule
`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame deframer testbench
// Streams frame bytes into the deframer and checks every payload item against
// a cycle-free predictor of the parser. A short directed table comes first,
// then random frames under several length windows and idle/stall patterns.
// ----------------------------------------------------------------------------
module testbench;
    import wsfd_pkg::*;

    localparam int PHASES       = 8;
    localparam int PHASE_BYTES  = 250;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 2000;
    localparam int SETTLE_TICKS = 4;
    localparam int MAX_REPORTS  = 10;

    typedef enum logic [2:0] {
        PH_FIRST, PH_SECOND, PH_LEN16, PH_LEN64, PH_KEY, PH_DATA
    } hdr_phase_t;

    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ITEM} row_chk_t;
    typedef enum logic [1:0] {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_enc_t;
    typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [OPC_W-1:0]  opc;
        logic              fin;
        logic              last;
    } payload_t;

    typedef struct packed {
        logic [BYTE_W-1:0] b;
        row_chk_t          chk;
        payload_t          want;
    } frame_row_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [BYTE_W-1:0]     s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [BYTE_W-1:0]     m_axis_tdata;
    logic [TUSER_W-1:0]    m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_LEN_W-1:0]  i_cfg_data;

    websocket_frame_deframer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Parser predictor: own copy of the window registers and header state
    // ------------------------------------------------------------------------
    logic [CFG_LEN_W-1:0] win_min, win_max;
    hdr_phase_t           m_phase;
    logic [CNT_W-1:0]     m_cnt;
    logic                 m_fin, m_masked, m_deliver;
    logic [OPC_W-1:0]     m_opc;
    logic [LEN_W-1:0]     m_len, m_idx;
    logic [KEY_W-1:0]     m_key;

    payload_t payload_q[$];

    int errors        = 0;
    int bytes_sent    = 0;
    int frames_sent   = 0;
    int results_seen  = 0;
    int tx_idle_pct   = 0;
    int rx_stall_pct  = 0;
    int hold_left     = 0;
    int quiet         = 0;

    // delivery is decided once per frame, when the header is complete
    function automatic void open_payload();
        m_deliver = (m_opc == OPC_TEXT || m_opc == OPC_BINARY) &&
                    m_len >= LEN_W'(win_min) && m_len <= LEN_W'(win_max);
        m_idx     = '0;
        m_phase   = (m_len == '0) ? PH_FIRST : PH_DATA;
    endfunction

    function automatic void end_length();
        m_cnt = '0;
        if (m_masked) m_phase = PH_KEY;
        else open_payload();
    endfunction

    function automatic bit track_byte(input logic [BYTE_W-1:0] b, output payload_t res);
        logic [CNT_W-1:0] need;
        logic [BYTE_W-1:0] d;
        res = '0;
        case (m_phase)
            PH_SECOND: begin
                m_masked = b[7];
                m_key    = '0;
                m_cnt    = '0;
                m_len    = '0;
                if (b[6:0] == LEN_CODE_EXT16) m_phase = PH_LEN16;
                else if (b[6:0] == LEN_CODE_EXT64) m_phase = PH_LEN64;
                else begin
                    m_len = LEN_W'(b[6:0]);
                    end_length();
                end
            end
            PH_LEN16, PH_LEN64: begin
                need  = (m_phase == PH_LEN16) ? EXT16_BYTES : EXT64_BYTES;
                m_len = {m_len[LEN_W-9:0], b};
                m_cnt = m_cnt + 1'b1;
                if (m_cnt >= need) end_length();
            end
            PH_KEY: begin
                m_key = {m_key[KEY_W-9:0], b};
                m_cnt = m_cnt + 1'b1;
                if (m_cnt >= KEY_BYTES) begin
                    m_cnt = '0;
                    open_payload();
                end
            end
            PH_DATA: begin
                // key bytes are applied most significant first
                d = b;
                if (m_masked) d = d ^ m_key[8 * (3 - m_idx[1:0]) +: 8];
                m_idx = m_idx + 1'b1;
                res = '{d, m_opc, m_fin, m_idx >= m_len};
                if (res.last) m_phase = PH_FIRST;
                return m_deliver;
            end
            default: begin
                // RSV bits are ignored
                m_fin   = b[7];
                m_opc   = b[3:0];
                m_phase = PH_SECOND;
            end
        endcase
        return 1'b0;
    endfunction

    // Keeps stray bytes from opening long frames: no 64-bit length codes and
    // 16-bit lengths below 512.
    function automatic logic [BYTE_W-1:0] tame(input logic [BYTE_W-1:0] b);
        if (m_phase == PH_SECOND && b[6:0] == LEN_CODE_EXT64) return {b[7], LEN_CODE_EXT16};
        if (m_phase == PH_LEN16 && m_cnt == '0) return {7'd0, b[0]};
        return b;
    endfunction

    // ------------------------------------------------------------------------
    // Output side: checker, stall pattern and long hold-off
    // ------------------------------------------------------------------------
    function automatic void note_failure(input string what, input payload_t want,
                                         input payload_t got);
        if (errors < MAX_REPORTS)
            $display("[%0t] %s: expected data=%h opc=%h fin=%b last=%b, got data=%h opc=%h fin=%b last=%b",
                     $realtime, what, want.data, want.opc, want.fin, want.last,
                     got.data, got.opc, got.fin, got.last);
        errors++;
    endfunction

    always @(posedge i_clk) begin : payload_sink
        payload_t got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tdata, m_axis_tuser[OPC_W-1:0], m_axis_tuser[OPC_W], m_axis_tlast};
            results_seen++;
            if (payload_q.size() == 0) begin
                note_failure("unexpected payload item", '0, got);
            end else begin
                want = payload_q.pop_front();
                if (got.data !== want.data || got.opc !== want.opc ||
                    got.fin !== want.fin || got.last !== want.last)
                    note_failure("payload mismatch", want, got);
            end
        end
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Watchdog on handshake activity
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || (i_cfg_valid && o_cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("[%0t] no handshake for %0d cycles, %0d payload items outstanding",
                     $realtime, quiet, payload_q.size());
            $display("Some tests failed");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [BYTE_W-1:0] b, input row_chk_t chk = CHK_MODEL,
                             input payload_t want = '0);
        payload_t got;
        bit hit;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        hit = track_byte(b, got);
        bytes_sent++;
        case (chk)
            CHK_MODEL: if (hit) payload_q.push_back(got);
            CHK_ITEM:  payload_q.push_back(want);
            default: ;
        endcase
    endtask

    // Stop offering, wait for every expected item, then let the pipe empty.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (payload_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_LEN_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == REG_MIN_LEN) win_min = val;
        else if (idx == REG_MAX_LEN) win_max = val;
    endtask

    task automatic send_frame(input logic [OPC_W-1:0] opc, input logic fin, input logic masked,
                              input logic [LEN_W-1:0] len, input len_enc_t enc, input int body);
        // realign on a header boundary after broken frames or noise
        while (m_phase != PH_FIRST) send_byte(tame(8'($urandom_range(255))));
        send_byte({fin, 3'($urandom_range(7)), opc});
        case (enc)
            LEN_SHORT: send_byte({masked, len[6:0]});
            LEN_EXT16: begin
                send_byte({masked, LEN_CODE_EXT16});
                send_byte(len[15:8]);
                send_byte(len[7:0]);
            end
            default: begin
                send_byte({masked, LEN_CODE_EXT64});
                for (int i = 7; i >= 0; i--) send_byte(len[8 * i +: 8]);
            end
        endcase
        if (masked) repeat (4) send_byte(8'($urandom_range(255)));
        repeat (body) send_byte(tame(8'($urandom_range(255))));
        frames_sent++;
    endtask

    // Mostly small frames, some on the window edges, some with extended
    // (possibly non-minimal) length fields, a few with a wrong byte count.
    task automatic send_random_frame();
        int roll, span, body, bound;
        len_enc_t enc;
        logic [OPC_W-1:0] opc;
        roll = $urandom_range(99);
        enc  = LEN_SHORT;
        if (roll < 55) begin
            span = $urandom_range(12);
        end else if (roll < 70) begin
            bound = $urandom_range(1) ? int'(win_min) : int'(win_max);
            span  = (bound <= 400) ? bound + $urandom_range(2) - 1 : $urandom_range(12);
            if (span < 0) span = 0;
        end else if (roll < 82) begin
            span = $urandom_range(125, 13);
        end else if (roll < 94) begin
            span = $urandom_range(400);
            enc  = LEN_EXT16;
        end else begin
            span = $urandom_range(300);
            enc  = LEN_EXT64;
        end
        if (enc == LEN_SHORT && span >= 126) enc = LEN_EXT16;
        body = span;
        if ($urandom_range(99) < 8) begin
            body = span + $urandom_range(6) - 3;
            if (body < 0) body = 0;
        end
        if ($urandom_range(99) < 70) opc = $urandom_range(1) ? OPC_TEXT : OPC_BINARY;
        else opc = OPC_W'($urandom_range(15));
        send_frame(opc, 1'($urandom_range(1)), 1'($urandom_range(1)), LEN_W'(span), enc, body);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    logic [CFG_LEN_W-1:0] phase_min [PHASES] =
        '{16'd0, 16'd3, 16'd20, 16'd0, 16'd1, 16'd100, 16'd12, 16'd5};
    logic [CFG_LEN_W-1:0] phase_max [PHASES] =
        '{16'hFFFF, 16'd10, 16'd5, 16'd0, 16'd1, 16'd400, 16'hFFFF, 16'd12};

    frame_row_t dir_rows [27];

    initial begin
        int target;
        bit drained;
        idle_mode_t mode;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;

        win_min   = MIN_LEN_RST;
        win_max   = MAX_LEN_RST;
        m_phase   = PH_FIRST;
        m_cnt     = '0;
        m_fin     = 1'b0;
        m_opc     = '0;
        m_masked  = 1'b0;
        m_len     = '0;
        m_key     = '0;
        m_idx     = '0;
        m_deliver = 1'b0;

        // Reset window is [4, 65534].
        dir_rows = '{
            // unmasked final text frame, 4 bytes: data passes straight through
            '{8'h81, CHK_NONE, '0},
            '{8'h04, CHK_NONE, '0},
            '{8'h00, CHK_ITEM, '{8'h00, OPC_TEXT, 1'b1, 1'b0}},
            '{8'hFF, CHK_ITEM, '{8'hFF, OPC_TEXT, 1'b1, 1'b0}},
            '{8'h55, CHK_ITEM, '{8'h55, OPC_TEXT, 1'b1, 1'b0}},
            '{8'hAA, CHK_ITEM, '{8'hAA, OPC_TEXT, 1'b1, 1'b1}},
            // masked binary, fin clear, all RSV bits set
            '{8'h72, CHK_NONE, '0},
            '{8'h84, CHK_NONE, '0},
            '{8'hFF, CHK_NONE, '0},
            '{8'h00, CHK_NONE, '0},
            '{8'hA5, CHK_NONE, '0},
            '{8'h5A, CHK_NONE, '0},
            '{8'h12, CHK_MODEL, '0},
            '{8'h34, CHK_MODEL, '0},
            '{8'h56, CHK_MODEL, '0},
            '{8'h78, CHK_MODEL, '0},
            // masked zero-length frame: key only, nothing out
            '{8'h81, CHK_NONE, '0},
            '{8'h80, CHK_NONE, '0},
            '{8'h01, CHK_NONE, '0},
            '{8'h02, CHK_NONE, '0},
            '{8'h03, CHK_NONE, '0},
            '{8'h04, CHK_NONE, '0},
            // binary frame below the minimum length
            '{8'h82, CHK_NONE, '0},
            '{8'h03, CHK_NONE, '0},
            '{8'h01, CHK_NONE, '0},
            '{8'h02, CHK_NONE, '0},
            '{8'h03, CHK_NONE, '0}
        };

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) send_byte(dir_rows[i].b, dir_rows[i].chk, dir_rows[i].want);
        frames_sent += 4;

        for (int p = 0; p < PHASES; p++) begin
            settle();
            write_reg(REG_MIN_LEN, phase_min[p]);
            write_reg((p == 0) ? {CFG_IDX_W{1'b1}} : CFG_IDX_W'($urandom_range(255, 2)),
                      (p == 0) ? 16'hFFFF : CFG_LEN_W'($urandom_range(16'hFFFF)));
            write_reg(REG_MAX_LEN, phase_max[p]);
            i_cfg_valid <= 1'b0;

            mode = idle_mode_t'(p % 4);
            case (mode)
                IDLE_NONE: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                IDLE_SEND: begin tx_idle_pct = 54; rx_stall_pct = 0;  end
                IDLE_RECV: begin tx_idle_pct = 0;  rx_stall_pct = 54; end
                default:   begin tx_idle_pct = 17; rx_stall_pct = 17; end
            endcase
            // wide-open window, no idling: a long output hold backs up the input
            if (p == 0) hold_left = HOLD_CYCLES;

            drained = 1'b0;
            target  = bytes_sent + PHASE_BYTES;
            while (bytes_sent < target) begin
                if (p == 1 && !drained && bytes_sent >= target - PHASE_BYTES / 2) begin
                    settle();
                    drained = 1'b1;
                end
                if ($urandom_range(99) < 7)
                    repeat ($urandom_range(4, 1)) send_byte(tame(8'($urandom_range(255))));
                else
                    send_random_frame();
            end
        end

        // 64-bit length with the top bit set: never completes, never delivered
        send_frame(OPC_BINARY, 1'b1, 1'b1, {1'b1, 31'($urandom), 32'($urandom)}, LEN_EXT64, 40);
        settle();

        if (payload_q.size() != 0) begin
            $display("%0d expected payload items never arrived", payload_q.size());
            errors += payload_q.size();
        end
        $display("Sent %0d bytes in about %0d frames across %0d length windows; %0d payload items checked.",
                 bytes_sent, frames_sent, PHASES + 1, results_seen);
        $display("Mix: masked/unmasked, 7/16/64-bit lengths, control and reserved opcodes, broken frames, %0d failures.",
                 errors);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
